// ----- hdl/tgrc_pkg.sv -----
package tgrc_pkg;

    // Timestamps are free-running millisecond counters that wrap at 2^16.
    localparam int TIME_BITS = 16;

    localparam int INTERACTION_BITS = 2;
    localparam int DIRECTION_BITS   = 3;

    // Configuration register indexes.
    localparam int                CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOLD_INTERVAL   = 2'd1;

    // Reset values of the configuration registers.
    localparam logic [TIME_BITS-1:0] REPEAT_INTERVAL_RESET = 16'd70;
    localparam logic [TIME_BITS-1:0] HOLD_INTERVAL_RESET   = 16'd400;

    // A move smaller than this on both axes counts as a press.
    localparam int DEADZONE_PX = 6;

    // Extra time after the repeat interval before a release ends a sequence.
    localparam logic [TIME_BITS:0] RELEASE_GRACE_MS = 17'd30;

    // Interaction codes.
    localparam logic [INTERACTION_BITS-1:0] INTER_NONE  = 2'd0;
    localparam logic [INTERACTION_BITS-1:0] INTER_PRESS = 2'd1;
    localparam logic [INTERACTION_BITS-1:0] INTER_SWIPE = 2'd2;

    // Direction codes.
    localparam logic [DIRECTION_BITS-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIRECTION_BITS-1:0] DIR_UP    = 3'd1;
    localparam logic [DIRECTION_BITS-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIRECTION_BITS-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIRECTION_BITS-1:0] DIR_RIGHT = 3'd4;

    // Classification of one movement.
    typedef struct packed {
        logic [INTERACTION_BITS-1:0] interaction;
        logic [DIRECTION_BITS-1:0]   direction;
    } gesture_t;

    // Elapsed time between two timestamps, modulo 2^16.
    function automatic logic [TIME_BITS-1:0] since(
        input logic [TIME_BITS-1:0] now,
        input logic [TIME_BITS-1:0] mark
    );
        since = now - mark;
    endfunction

endpackage

// ----- hdl/tgrc_classify.sv -----
// Classifies the movement from the sequence origin to the current point.
module tgrc_classify #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] point_x,
    input  logic [COORD_BITS-1:0] point_y,
    input  logic [COORD_BITS-1:0] origin_x,
    input  logic [COORD_BITS-1:0] origin_y,
    output tgrc_pkg::gesture_t    gesture
);

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic        [COORD_BITS:0] ax;
    logic        [COORD_BITS:0] ay;
    logic                       in_deadzone;

    assign dx = $signed({1'b0, point_x}) - $signed({1'b0, origin_x});
    assign dy = $signed({1'b0, point_y}) - $signed({1'b0, origin_y});
    assign ax = dx[COORD_BITS] ? unsigned'(-dx) : unsigned'(dx);
    assign ay = dy[COORD_BITS] ? unsigned'(-dy) : unsigned'(dy);

    assign in_deadzone = (ax < (COORD_BITS+1)'(tgrc_pkg::DEADZONE_PX)) &&
                         (ay < (COORD_BITS+1)'(tgrc_pkg::DEADZONE_PX));

    always_comb
    begin
        gesture.interaction = in_deadzone ? tgrc_pkg::INTER_PRESS : tgrc_pkg::INTER_SWIPE;
        // The vertical axis wins when both magnitudes are equal.
        if (ax > ay)
        begin
            gesture.direction = dx[COORD_BITS] ? tgrc_pkg::DIR_LEFT : tgrc_pkg::DIR_RIGHT;
        end
        else if (dy[COORD_BITS])
        begin
            gesture.direction = tgrc_pkg::DIR_UP;
        end
        else if (dy != '0)
        begin
            gesture.direction = tgrc_pkg::DIR_DOWN;
        end
        else
        begin
            gesture.direction = tgrc_pkg::DIR_NONE;
        end
    end

endmodule

// ----- hdl/touch_gesture_repeat_classifier.sv -----
// Touch gesture classifier with auto-repeat. Each poll request carries a
// millisecond timestamp, a touch flag and the touch point. The block takes
// one poll request in every clock cycle while its input is not stalled:
// a poll is captured in an input register, the phase machine and the
// movement classifier evaluate it there, and any event lands in the
// result register. The result register lets a new poll enter while a
// finished event still waits downstream; only when the result register
// is full and stalled does the block stall its input. At most
// one event comes out of each poll. The first event of a touch is emitted
// once more than repeat_interval_ms has passed since touch-down and reports
// press or swipe with the dominant direction; after hold_interval_ms more
// the same classification repeats every repeat_interval_ms at the current
// point. All time differences wrap modulo 2^16. Configuration writes are
// always taken at once and should only be made while the block is idle.
module touch_gesture_repeat_classifier #(
    parameter int COORD_BITS = 12
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    // Poll channel.
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic [tgrc_pkg::TIME_BITS-1:0]          now_ms,
    input  logic                                    touch_active,
    input  logic [COORD_BITS-1:0]                   point_x,
    input  logic [COORD_BITS-1:0]                   point_y,

    // Event channel.
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic [tgrc_pkg::INTERACTION_BITS-1:0]   interaction,
    output logic [tgrc_pkg::DIRECTION_BITS-1:0]     direction,
    output logic [COORD_BITS-1:0]                   event_x,
    output logic [COORD_BITS-1:0]                   event_y,

    // Configuration write channel.
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [tgrc_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [tgrc_pkg::TIME_BITS-1:0]          cfg_data
);

    localparam int TB = tgrc_pkg::TIME_BITS;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_STARTED = 3'd1,
        PH_SINGLE  = 3'd2,
        PH_WAIT    = 3'd3,
        PH_REPEAT  = 3'd4
    } phase_t;

    // Configuration.
    logic [TB-1:0]           repeat_interval_reg;
    logic [TB-1:0]           hold_interval_reg;

    // Input register.
    logic                    item_v_reg;
    logic [TB-1:0]           now_reg;
    logic                    touch_reg;
    logic [COORD_BITS-1:0]   px_reg;
    logic [COORD_BITS-1:0]   py_reg;

    // Sequence state.
    phase_t                  phase_reg, phase_next;
    logic [TB-1:0]           start_ms_reg, start_ms_next;
    logic [TB-1:0]           first_ms_reg, first_ms_next;
    logic [TB-1:0]           last_ms_reg, last_ms_next;
    logic [COORD_BITS-1:0]   origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0]   origin_y_reg, origin_y_next;
    tgrc_pkg::gesture_t      held_reg, held_next;

    // Result register.
    logic                    result_v_reg;
    tgrc_pkg::gesture_t      result_gesture_reg;
    logic [COORD_BITS-1:0]   result_x_reg;
    logic [COORD_BITS-1:0]   result_y_reg;

    logic                    advance;
    logic                    emit;
    logic                    result_taken;
    tgrc_pkg::gesture_t      gesture;
    logic [TB-1:0]           since_start;
    logic [TB-1:0]           since_first;
    logic [TB-1:0]           since_last;

    tgrc_classify #(
        .COORD_BITS (COORD_BITS)
    ) u_classify (
        .point_x  (px_reg),
        .point_y  (py_reg),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .gesture  (gesture)
    );

    // The poll in the input register is evaluated whenever the result
    // register has room for a possible event this cycle.
    assign result_taken = result_v_reg && !result_stall;
    assign advance      = item_v_reg && (!result_v_reg || !result_stall);
    assign item_stall   = item_v_reg && result_v_reg && result_stall;
    assign cfg_ready    = 1'b1;

    assign since_start = tgrc_pkg::since(now_reg, start_ms_reg);
    assign since_first = tgrc_pkg::since(now_reg, first_ms_reg);
    assign since_last  = tgrc_pkg::since(now_reg, last_ms_reg);

    always_comb
    begin
        phase_next    = phase_reg;
        start_ms_next = start_ms_reg;
        first_ms_next = first_ms_reg;
        last_ms_next  = last_ms_reg;
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        held_next     = held_reg;
        emit          = 1'b0;

        if (!touch_reg)
        begin
            // The grace sum is formed one bit wider, so it never wraps.
            if (phase_reg != PH_IDLE &&
                {1'b0, since_start} > ({1'b0, repeat_interval_reg} + tgrc_pkg::RELEASE_GRACE_MS))
            begin
                phase_next            = PH_IDLE;
                held_next.interaction = tgrc_pkg::INTER_NONE;
                held_next.direction   = tgrc_pkg::DIR_NONE;
            end
        end
        else
        begin
            case (phase_reg)
                PH_STARTED:
                begin
                    if (since_start > repeat_interval_reg)
                    begin
                        held_next     = gesture;
                        first_ms_next = now_reg;
                        phase_next    = PH_SINGLE;
                        emit          = 1'b1;
                    end
                end
                PH_SINGLE:
                begin
                    if (since_first > (repeat_interval_reg >> 2))
                    begin
                        phase_next = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (since_first > hold_interval_reg)
                    begin
                        phase_next   = PH_REPEAT;
                        last_ms_next = now_reg;
                    end
                end
                PH_REPEAT:
                begin
                    if (since_last > repeat_interval_reg)
                    begin
                        last_ms_next = now_reg;
                        emit         = 1'b1;
                    end
                end
                default:
                begin
                    // Touch-down: remember where and when the sequence began.
                    origin_x_next = px_reg;
                    origin_y_next = py_reg;
                    start_ms_next = now_reg;
                    phase_next    = PH_STARTED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repeat_interval_reg <= tgrc_pkg::REPEAT_INTERVAL_RESET;
            hold_interval_reg   <= tgrc_pkg::HOLD_INTERVAL_RESET;
            item_v_reg          <= 1'b0;
            now_reg             <= '0;
            touch_reg           <= 1'b0;
            px_reg              <= '0;
            py_reg              <= '0;
            phase_reg           <= PH_IDLE;
            start_ms_reg        <= '0;
            first_ms_reg        <= '0;
            last_ms_reg         <= '0;
            origin_x_reg        <= '0;
            origin_y_reg        <= '0;
            held_reg            <= '0;
            result_v_reg        <= 1'b0;
            result_gesture_reg  <= '0;
            result_x_reg        <= '0;
            result_y_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tgrc_pkg::CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                    tgrc_pkg::CFG_HOLD_INTERVAL:   hold_interval_reg   <= cfg_data;
                    default:                       ;
                endcase
            end

            if (!item_stall)
            begin
                item_v_reg <= item_valid;
                if (item_valid)
                begin
                    now_reg   <= now_ms;
                    touch_reg <= touch_active;
                    px_reg    <= point_x;
                    py_reg    <= point_y;
                end
            end

            if (advance)
            begin
                phase_reg    <= phase_next;
                start_ms_reg <= start_ms_next;
                first_ms_reg <= first_ms_next;
                last_ms_reg  <= last_ms_next;
                origin_x_reg <= origin_x_next;
                origin_y_reg <= origin_y_next;
                held_reg     <= held_next;
            end

            if (advance && emit)
            begin
                result_v_reg       <= 1'b1;
                result_gesture_reg <= held_next;
                result_x_reg       <= px_reg;
                result_y_reg       <= py_reg;
            end
            else if (result_taken)
            begin
                result_v_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_v_reg;
    assign interaction  = result_gesture_reg.interaction;
    assign direction    = result_gesture_reg.direction;
    assign event_x      = result_x_reg;
    assign event_y      = result_y_reg;

    // An event always carries a real classification.
    a_event_classified: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (interaction == tgrc_pkg::INTER_PRESS ||
                          interaction == tgrc_pkg::INTER_SWIPE))
        else $error("event without a classification");

    // Once the first event has gone out, the held classification is set.
    a_held_after_event: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SINGLE || phase_reg == PH_WAIT || phase_reg == PH_REPEAT)
        |-> held_reg.interaction != tgrc_pkg::INTER_NONE)
        else $error("held classification lost after the first event");

    // The input stalls only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (item_v_reg && result_v_reg && result_stall))
        else $error("input stalled without a blocked result");

    // A poll that sat stalled is evaluated later, never dropped.
    a_stalled_poll_kept: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |=> item_v_reg)
        else $error("stalled poll was dropped");

endmodule

// ----- verif/touch_gesture_repeat_classifier_tb.sv -----
`timescale 1ns / 100ps

module touch_gesture_repeat_classifier_tb;

    localparam int COORD_W   = 12;
    localparam int COORD_MAX = (1 << COORD_W) - 1;
    localparam int TIME_W    = tgrc_pkg::TIME_BITS;

    // Extra cycles after the last owed event cover any poll that is still in
    // flight but produces no event.
    localparam int SETTLE_CYCLES = 4;

    // Register indexes past the end of the register list; writes to them
    // must be ignored.
    localparam logic [tgrc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [tgrc_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [2:0] {
        TP_IDLE,
        TP_STARTED,
        TP_SINGLE,
        TP_WAIT,
        TP_REPEAT
    } touch_phase_t;

    typedef struct packed {
        tgrc_pkg::gesture_t     gesture;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
    } touch_event_t;

    // Scoreboard: tracks the gesture phase machine and holds the events that
    // are still owed by the block.
    class gesture_scoreboard_t;
        logic [TIME_W-1:0]      repeat_ms;
        logic [TIME_W-1:0]      hold_ms;
        touch_phase_t           phase;
        logic [TIME_W-1:0]      start_ms;
        logic [TIME_W-1:0]      first_ms;
        logic [TIME_W-1:0]      repeat_mark_ms;
        logic [COORD_W-1:0]     origin_x;
        logic [COORD_W-1:0]     origin_y;
        tgrc_pkg::gesture_t     held;
        touch_event_t           owed_events[$];
        int                     poll_count;
        int                     event_count;
        int                     fail_count;

        function new();
            repeat_ms      = tgrc_pkg::REPEAT_INTERVAL_RESET;
            hold_ms        = tgrc_pkg::HOLD_INTERVAL_RESET;
            phase          = TP_IDLE;
            start_ms       = '0;
            first_ms       = '0;
            repeat_mark_ms = '0;
            origin_x       = '0;
            origin_y       = '0;
            held.interaction = tgrc_pkg::INTER_NONE;
            held.direction   = tgrc_pkg::DIR_NONE;
            poll_count     = 0;
            event_count    = 0;
            fail_count     = 0;
        endfunction

        function logic [TIME_W-1:0] span_ms(input logic [TIME_W-1:0] t,
                                            input logic [TIME_W-1:0] mark);
            return t - mark;
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        function void write_config(input logic [tgrc_pkg::CFG_INDEX_BITS-1:0] idx,
                                   input logic [TIME_W-1:0] data);
            if (idx == tgrc_pkg::CFG_REPEAT_INTERVAL)
                repeat_ms = data;
            else if (idx == tgrc_pkg::CFG_HOLD_INTERVAL)
                hold_ms = data;
        endfunction

        function void owe_event(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
            touch_event_t ev;
            ev.gesture = held;
            ev.x       = x;
            ev.y       = y;
            owed_events.push_back(ev);
        endfunction

        function void note_poll(input logic [TIME_W-1:0] t, input logic touch,
                                input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
            logic [TIME_W:0] grace;
            int xi, yi, oxi, oyi, dx, dy, ax, ay;
            poll_count++;
            grace = {1'b0, repeat_ms} + tgrc_pkg::RELEASE_GRACE_MS;
            if (!touch) begin
                if (phase != TP_IDLE && {1'b0, span_ms(t, start_ms)} > grace) begin
                    phase            = TP_IDLE;
                    held.interaction = tgrc_pkg::INTER_NONE;
                    held.direction   = tgrc_pkg::DIR_NONE;
                end
                return;
            end
            case (phase)
                TP_STARTED: begin
                    if (span_ms(t, start_ms) > repeat_ms) begin
                        xi  = int'(x);
                        yi  = int'(y);
                        oxi = int'(origin_x);
                        oyi = int'(origin_y);
                        dx  = xi - oxi;
                        dy  = yi - oyi;
                        ax  = (dx < 0) ? -dx : dx;
                        ay  = (dy < 0) ? -dy : dy;
                        held.interaction = (ax < tgrc_pkg::DEADZONE_PX &&
                                            ay < tgrc_pkg::DEADZONE_PX) ?
                                           tgrc_pkg::INTER_PRESS : tgrc_pkg::INTER_SWIPE;
                        if (ax > ay)
                            held.direction = (dx > 0) ? tgrc_pkg::DIR_RIGHT
                                                      : tgrc_pkg::DIR_LEFT;
                        else if (dy > 0)
                            held.direction = tgrc_pkg::DIR_DOWN;
                        else if (dy < 0)
                            held.direction = tgrc_pkg::DIR_UP;
                        else
                            held.direction = tgrc_pkg::DIR_NONE;
                        first_ms = t;
                        phase    = TP_SINGLE;
                        owe_event(x, y);
                    end
                end
                TP_SINGLE: begin
                    if (span_ms(t, first_ms) > (repeat_ms >> 2))
                        phase = TP_WAIT;
                end
                TP_WAIT: begin
                    if (span_ms(t, first_ms) > hold_ms) begin
                        phase          = TP_REPEAT;
                        repeat_mark_ms = t;
                    end
                end
                TP_REPEAT: begin
                    if (span_ms(t, repeat_mark_ms) > repeat_ms) begin
                        repeat_mark_ms = t;
                        owe_event(x, y);
                    end
                end
                default: begin
                    origin_x = x;
                    origin_y = y;
                    start_ms = t;
                    phase    = TP_STARTED;
                end
            endcase
        endfunction

        function void compare_field(input string field, input logic [15:0] want,
                                    input logic [15:0] got);
            if (got !== want) begin
                $display("%0t: event %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
                fail_count++;
            end
        endfunction

        function void check_event(input logic [tgrc_pkg::INTERACTION_BITS-1:0] inter,
                                  input logic [tgrc_pkg::DIRECTION_BITS-1:0] dir,
                                  input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
            touch_event_t want;
            if (owed_events.size() == 0) begin
                $display("%0t: event request mismatch, expected none, actual %0d/%0d at (%0d,%0d)",
                         $time, inter, dir, x, y);
                fail_count++;
                return;
            end
            want = owed_events.pop_front();
            event_count++;
            compare_field("interaction", 16'(want.gesture.interaction), 16'(inter));
            compare_field("direction", 16'(want.gesture.direction), 16'(dir));
            compare_field("event_x", 16'(want.x), 16'(x));
            compare_field("event_y", 16'(want.y), 16'(y));
        endfunction
    endclass

    logic                                       clk;
    logic                                       rst_n;

    logic                                       item_valid;
    logic                                       item_stall;
    logic [TIME_W-1:0]                          now_ms;
    logic                                       touch_active;
    logic [COORD_W-1:0]                         point_x;
    logic [COORD_W-1:0]                         point_y;

    logic                                       result_valid;
    logic                                       result_stall;
    logic [tgrc_pkg::INTERACTION_BITS-1:0]      interaction;
    logic [tgrc_pkg::DIRECTION_BITS-1:0]        direction;
    logic [COORD_W-1:0]                         event_x;
    logic [COORD_W-1:0]                         event_y;

    logic                                       cfg_valid;
    logic                                       cfg_ready;
    logic [tgrc_pkg::CFG_INDEX_BITS-1:0]        cfg_index;
    logic [TIME_W-1:0]                          cfg_data;

    gesture_scoreboard_t                        sb;

    // Panel time base used by the gesture generator; it wraps like the
    // panel's own counter.
    logic [TIME_W-1:0]                          panel_ms;

    // Percentages of cycles in which the poll side holds back and the event
    // side stalls.
    int                                         send_idle_pct;
    int                                         recv_stall_pct;
    int                                         settings_run;

    touch_gesture_repeat_classifier #(
        .COORD_BITS     (COORD_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .now_ms         (now_ms),
        .touch_active   (touch_active),
        .point_x        (point_x),
        .point_y        (point_y),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .interaction    (interaction),
        .direction      (direction),
        .event_x        (event_x),
        .event_y        (event_y),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Hard limit on the run; a correct run ends far sooner.
    initial
    begin
        #2_000_000;
        $display("FAIL touch_gesture_repeat_classifier");
        $finish;
    end

    // The event side stalls at random according to the current setting.
    always @(posedge clk)
    begin
        result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // An event request is taken at an edge where valid is high and our stall
    // was low; both are read before this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_event(interaction, direction, event_x, event_y);
    end

    // Offers one poll request, with random idle cycles ahead of it, and holds
    // it steady until the block takes it.
    task automatic send_poll(input logic [TIME_W-1:0] t, input logic touch,
                             input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        now_ms       <= t;
        touch_active <= touch;
        point_x      <= x;
        point_y      <= y;
        do
            @(posedge clk);
        while (item_stall);
        sb.note_poll(t, touch, x, y);
    endtask

    // Stops sending, waits until every owed event has come out, then lets
    // any poll that produces nothing clear the pipeline.
    task automatic drain_events();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Presents one register write and leaves valid high; the caller lowers
    // it once the last write of a group has gone in.
    task automatic write_reg(input logic [tgrc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_config(idx, data);
    endtask

    function automatic int clamp_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // Time between polls: mostly small against the repeat interval so that
    // every phase is visited, sometimes zero to hit the strict compare, and
    // now and then a jump anywhere on the clock.
    function automatic int pick_step(input int step_max);
        case ($urandom_range(0, 31))
            0:       return $urandom_range(0, 65535);
            1, 2, 3: return 0;
            default: return $urandom_range(1, step_max);
        endcase
    endfunction

    // Corner cases at the reset intervals (repeat 70 ms, hold 400 ms).
    task automatic run_directed();
        // A release while idle does nothing.
        send_poll(16'd65500, 1'b0, 12'd0, 12'd0);
        // Touch-down at the top corner of both axes, just before the
        // timestamp wraps.
        send_poll(16'd65500, 1'b1, 12'd4095, 12'd4095);
        // Exactly the repeat interval across the wrap: not yet.
        send_poll(16'd34, 1'b1, 12'd0, 12'd0);
        // One more millisecond: swipe with equal magnitudes, so up wins.
        send_poll(16'd35, 1'b1, 12'd0, 12'd0);
        // Quarter interval (17 ms) boundary into the wait phase.
        send_poll(16'd52, 1'b1, 12'd0, 12'd0);
        send_poll(16'd53, 1'b1, 12'd0, 12'd0);
        // Hold interval boundary into repeat.
        send_poll(16'd435, 1'b1, 12'd100, 12'd200);
        send_poll(16'd436, 1'b1, 12'd100, 12'd200);
        // First repeat at the repeat interval plus one, at a new point.
        send_poll(16'd506, 1'b1, 12'd4095, 12'd0);
        send_poll(16'd507, 1'b1, 12'd4095, 12'd0);
        // Release well past the grace time ends the sequence.
        send_poll(16'd520, 1'b0, 12'd0, 12'd4095);
        // A short lift before the grace time runs out keeps the sequence.
        send_poll(16'd600, 1'b1, 12'd1000, 12'd1000);
        send_poll(16'd650, 1'b0, 12'd1000, 12'd1000);
        send_poll(16'd700, 1'b0, 12'd1000, 12'd1000);
        // Inside the deadzone with equal magnitudes: a press going up.
        send_poll(16'd701, 1'b1, 12'd1005, 12'd995);
        send_poll(16'd800, 1'b0, 12'd0, 12'd0);
        // No movement at all: a press with no direction.
        send_poll(16'd900, 1'b1, 12'd2000, 12'd2000);
        send_poll(16'd1000, 1'b1, 12'd2000, 12'd2000);
        send_poll(16'd1100, 1'b0, 12'd0, 12'd0);
        // Six pixels to the right is just outside the deadzone.
        send_poll(16'd1200, 1'b1, 12'd2000, 12'd2000);
        send_poll(16'd1300, 1'b1, 12'd2006, 12'd2003);
        send_poll(16'd1400, 1'b0, 12'd0, 12'd0);
        // Six pixels to the left, one down: a left swipe.
        send_poll(16'd1500, 1'b1, 12'd2000, 12'd2000);
        send_poll(16'd1600, 1'b1, 12'd1994, 12'd2001);
        send_poll(16'd1700, 1'b0, 12'd0, 12'd0);
        panel_ms = 16'd1700;
    endtask

    // Random touch gestures: a touch-down, a run of held polls that either
    // jitter around the origin or slide toward a target, then a release that
    // lasts past the grace time. About one gesture in ten is replaced by a
    // single poll of pure noise, and a held poll now and then drops the touch flag.
    task automatic run_gestures(input int n_polls);
        int sent, len, step_max, k, r, releases;
        int ox, oy, tx, ty, px, py;
        bit is_press, paused;
        sent     = 0;
        paused   = 0;
        step_max = (sb.repeat_ms > 3000) ? 1000 : sb.repeat_ms / 3 + 1;
        while (sent < n_polls)
        begin
            // Halfway through, the poll side waits for every owed event.
            if (!paused && sent >= n_polls / 2)
            begin
                drain_events();
                paused = 1;
            end
            if ($urandom_range(0, 9) == 0)
            begin
                send_poll(TIME_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
                          COORD_W'($urandom_range(0, COORD_MAX)),
                          COORD_W'($urandom_range(0, COORD_MAX)));
                sent++;
            end
            else
            begin
                ox = ($urandom_range(0, 7) == 0) ? COORD_MAX * $urandom_range(0, 1)
                                                 : $urandom_range(0, COORD_MAX);
                oy = ($urandom_range(0, 7) == 0) ? COORD_MAX * $urandom_range(0, 1)
                                                 : $urandom_range(0, COORD_MAX);
                is_press = ($urandom_range(0, 4) < 2);
                tx  = int'($urandom_range(0, 1200)) - 600;
                ty  = int'($urandom_range(0, 1200)) - 600;
                len = $urandom_range(2, 40);
                for (k = 0; k < len; k++)
                begin
                    if (k != 0)
                        panel_ms = panel_ms + TIME_W'(pick_step(step_max));
                    if (is_press)
                    begin
                        px = clamp_coord(ox + int'($urandom_range(0, 12)) - 6);
                        py = clamp_coord(oy + int'($urandom_range(0, 12)) - 6);
                    end
                    else
                    begin
                        px = clamp_coord(ox + tx * k / len);
                        py = clamp_coord(oy + ty * k / len);
                    end
                    send_poll(panel_ms, (k == 0) || ($urandom_range(0, 15) != 0),
                              COORD_W'(px), COORD_W'(py));
                    sent++;
                end
                releases = $urandom_range(1, 3);
                for (r = 0; r < releases; r++)
                begin
                    if (r == releases - 1)
                        panel_ms = panel_ms + sb.repeat_ms +
                                   TIME_W'(31 + $urandom_range(0, 40));
                    else
                        panel_ms = panel_ms + TIME_W'(pick_step(step_max));
                    send_poll(panel_ms, 1'b0, COORD_W'($urandom_range(0, COORD_MAX)),
                              COORD_W'($urandom_range(0, COORD_MAX)));
                    sent++;
                end
            end
        end
    endtask

    // New interval settings go in only once the block has gone quiet.
    task automatic run_setting(input logic [TIME_W-1:0] rep,
                               input logic [TIME_W-1:0] hold,
                               input int idle_pct, input int stall_pct, input int n_polls);
        drain_events();
        write_reg(tgrc_pkg::CFG_REPEAT_INTERVAL, rep);
        write_reg(tgrc_pkg::CFG_HOLD_INTERVAL, hold);
        cfg_valid      <= 1'b0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        settings_run++;
        run_gestures(n_polls);
    endtask

    initial
    begin
        sb = new();
        rst_n          <= 1'b0;
        item_valid     <= 1'b0;
        now_ms         <= '0;
        touch_active   <= 1'b0;
        point_x        <= '0;
        point_y        <= '0;
        result_stall   <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_index      <= tgrc_pkg::CFG_REPEAT_INTERVAL;
        cfg_data       <= '0;
        panel_ms       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        settings_run   = 1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset intervals, no idling on either side.
        run_directed();
        run_gestures(250);

        // Zero intervals: every touched poll with a new timestamp moves the machine on.
        run_setting(16'd0, 16'd0, 75, 0, 100);
        // Full-scale intervals: the strict compare can never pass.
        run_setting(16'hFFFF, 16'hFFFF, 0, 75, 60);
        run_setting(16'd12, 16'd30, 28, 28, 150);
        // Grace time no longer fits in 16 bits, so a release never ends
        // the sequence.
        run_setting(16'd65506, 16'd5, 75, 0, 80);

        // Writes past the register list must leave both intervals alone.
        drain_events();
        write_reg(CFG_SPARE_A, TIME_W'($urandom_range(0, 65535)));
        write_reg(CFG_SPARE_B, TIME_W'($urandom_range(0, 65535)));
        cfg_valid <= 1'b0;
        run_setting(tgrc_pkg::REPEAT_INTERVAL_RESET, tgrc_pkg::HOLD_INTERVAL_RESET,
                    0, 75, 160);
        run_setting(TIME_W'($urandom_range(1, 200)), TIME_W'($urandom_range(0, 600)),
                    28, 28, 150);

        drain_events();
        $display("Run covered %0d poll requests and %0d events over %0d interval settings,",
                 sb.poll_count, sb.event_count, settings_run);
        $display("from zero to full-scale intervals, with idling from none up to 3 in 4.");
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("PASS touch_gesture_repeat_classifier");
        else
            $display("FAIL touch_gesture_repeat_classifier");
        $finish;
    end

endmodule
